/* sv/bdht_pkg.sv */
// package: item types, register indexes and constants of the button debouncer
package bdht_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE       = 2'd0,
    OP_READ_PRESS   = 2'd1,
    OP_READ_RELEASE = 2'd2,
    OP_RESTART      = 2'd3
  } op_e;

  typedef enum logic {
    REG_TRIP_COUNT   = 1'b0,
    REG_ACTIVE_LEVEL = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e         operation;
    logic        pin_level;
    logic [31:0] time_us;
    logic        start_active;
  } in_item_t;

  typedef struct packed {
    logic        level_matches;
    logic        debounced_active;
    logic [15:0] held_ms;
    logic        event_flag;
    logic [15:0] released_held_ms;
  } out_item_t;

  typedef struct packed {
    logic [7:0] trip_count;
    logic       active_level;
  } cfg_t;

  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0]  TRIP_COUNT_RST   = 8'd4;
  localparam logic        ACTIVE_LEVEL_RST = 1'b0;

  // x / 1000 == (x * MS_RECIP) >> MS_SHIFT for every 32-bit x
  localparam int unsigned MS_SHIFT = 38;
  localparam int unsigned ProdW    = 61;
  localparam logic [28:0] MS_RECIP = 29'd274877907;

  localparam logic [15:0] HELD_MAX = 16'hFFFF;

endpackage

/* sv/bdht_held_calc.sv */
// elapsed milliseconds since press start, truncated to 16 bits
module bdht_held_calc import bdht_pkg::*; (
  input  logic [31:0] now_i,
  input  logic [31:0] start_i,
  output logic [15:0] fresh_ms_o
);

  logic [31:0]      elapsed;
  logic [ProdW-1:0] prod;

  assign elapsed    = now_i - start_i;
  assign prod       = ProdW'(elapsed) * ProdW'(MS_RECIP);
  assign fresh_ms_o = prod[MS_SHIFT +: 16];

endmodule

/* sv/bdht_core.sv */
// debounce state, hold time and event flags, updated once per item
module bdht_core import bdht_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic        state_q, state_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] start_q, start_d;
  logic [15:0] held_q, held_d;
  logic [15:0] rel_held_q, rel_held_d;
  logic        press_q, press_d;
  logic        release_q, release_d;

  logic [15:0] fresh_ms;
  logic        lvl_hit;
  logic [7:0]  cnt;
  logic        flip;

  bdht_held_calc u_held_calc (
    .now_i      (item_i.time_us),
    .start_i    (start_q),
    .fresh_ms_o (fresh_ms)
  );

  assign lvl_hit = (item_i.pin_level == cfg_i.active_level);
  assign cnt     = (lvl_hit != state_q) ? count_q + 8'd1 : 8'd0;
  assign flip    = (cnt >= cfg_i.trip_count);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    start_d    = start_q;
    held_d     = held_q;
    rel_held_d = rel_held_q;
    press_d    = press_q;
    release_d  = release_q;
    res_o      = '0;
    case (item_i.operation)
      OP_SAMPLE: begin
        res_o.level_matches = lvl_hit;
        count_d = flip ? 8'd0 : cnt;
        if (flip && !state_q) begin
          // press: elapsed time starts at zero, reported as one
          state_d = 1'b1;
          start_d = item_i.time_us;
          press_d = 1'b1;
          held_d  = 16'd1;
        end else if (flip) begin
          state_d    = 1'b0;
          release_d  = 1'b1;
          rel_held_d = held_q;
          start_d    = '0;
          held_d     = '0;
        end else if (state_q) begin
          if (fresh_ms < held_q) begin
            held_d = HELD_MAX;
          end else if (fresh_ms == 16'd0) begin
            held_d = 16'd1;
          end else begin
            held_d = fresh_ms;
          end
        end else begin
          held_d = '0;
        end
      end
      OP_READ_PRESS: begin
        res_o.event_flag = press_q;
        press_d = 1'b0;
      end
      OP_READ_RELEASE: begin
        res_o.event_flag       = release_q;
        res_o.released_held_ms = release_q ? rel_held_q : 16'd0;
        release_d = 1'b0;
      end
      OP_RESTART: begin
        start_d    = item_i.time_us;
        held_d     = '0;
        rel_held_d = '0;
        press_d    = 1'b0;
        release_d  = 1'b0;
        count_d    = '0;
        state_d    = item_i.start_active;
      end
      default: begin
        state_d = state_q;
      end
    endcase
    res_o.debounced_active = state_d;
    res_o.held_ms          = held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= 1'b0;
      count_q    <= '0;
      start_q    <= '0;
      held_q     <= '0;
      rel_held_q <= '0;
      press_q    <= 1'b0;
      release_q  <= 1'b0;
    end else if (fire_i) begin
      state_q    <= state_d;
      count_q    <= count_d;
      start_q    <= start_d;
      held_q     <= held_d;
      rel_held_q <= rel_held_d;
      press_q    <= press_d;
      release_q  <= release_d;
    end
  end

endmodule

/* sv/button_debounce_hold_timer_top.sv */
// top level: input register, debounce core, result register and config registers
// order: input register, core, result register; an output stall holds the item in place
// throughput: one item per cycle while the output is not stalled; the state update (subtract,
//   multiply by the reciprocal of 1000, compare) is combinational between the registers
// reset: asynchronous active low; clears all state and flags, debounce level
//   returns to 4 and active level to 0
module button_debounce_hold_timer_top import bdht_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  cfg_reg_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  cfg_t      cfg_q;
  out_item_t res;
  logic      fire;

  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  bdht_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trip_count   <= TRIP_COUNT_RST;
      cfg_q.active_level <= ACTIVE_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TRIP_COUNT:   cfg_q.trip_count   <= cfg_data_i;
        REG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_data_i[0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

endmodule

/* sv/bdht_checker.sv */
// port-level checks of the button debouncer, bound to the top level
module bdht_checker import bdht_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a released button never shows a hold time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.debounced_active |-> out_item_o.held_ms == 16'd0)
    else $error("held time nonzero while released");

  // a release time only comes with a set release flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.event_flag |-> out_item_o.released_held_ms == 16'd0)
    else $error("release time without flag");

  // a sample item with a matching level never reports an event flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.level_matches |-> !out_item_o.event_flag)
    else $error("sample item with event flag");

  // input side only stalls behind a full, stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

endmodule

bind button_debounce_hold_timer_top bdht_checker u_bdht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
